// File: rtl/rbi_pkg.sv
// Shared types and constants for the rectilinear bilinear interpolation unit.
package rbi_pkg;

    localparam int GRID_DEPTH_DEF   = 256;
    localparam int SAMPLE_DEPTH_DEF = 65536;

    localparam int NUM_W  = 86;   // signed numerator sum, Q.16
    localparam int PROD_W = 59;   // 33 x 26 signed product
    localparam int DM_W   = 50;   // |den| << 16
    localparam int DIV_CW = 7;    // bit counter of the divider

    localparam logic [1:0] CMD_WR_X   = 2'd0;
    localparam logic [1:0] CMD_WR_Y   = 2'd1;
    localparam logic [1:0] CMD_WR_SMP = 2'd2;
    localparam logic [1:0] CMD_QUERY  = 2'd3;

    localparam logic [1:0] CFG_LAST_X   = 2'd0;
    localparam logic [1:0] CFG_LAST_Y   = 2'd1;
    localparam logic [1:0] CFG_ROW_STEP = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_SAT  = 2'd1;
    localparam logic [1:0] ST_ZERO = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH_RD,
        S_SEARCH_CMP,
        S_LO_RD,
        S_HI_RD,
        S_HI_CAP,
        S_DEN,
        S_SMP,
        S_MAC,
        S_DIV_INIT,
        S_DIV,
        S_DONE
    } rbi_state_t;

endpackage

// File: rtl/rectilinear_bilinear_interp_unit.sv
// Rectilinear grid bilinear interpolation unit: tables, sample store and query engine.
// Write beats produce no result; a query holds off the next beat. A query binary-searches
// both axes at once, up to ceil(log2(bound+1)) steps per axis (8 at bound 255), then reads the
// cell corners and four samples, forms the numerator on one multiplier and divides bit-serially;
// a zero cell span skips the samples, MAC and divider. A query waits in its last state while
// the previous result is still held. Reset clears control state.
module rectilinear_bilinear_interp_unit
    import rbi_pkg::*;
#(
    parameter int GRID_DEPTH   = GRID_DEPTH_DEF,
    parameter int SAMPLE_DEPTH = SAMPLE_DEPTH_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [8:0]   cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // address[15:0], coord_value[31:16], sample_value[63:32], query_x[87:64], query_y[111:88]
    input  logic [111:0] s_tdata,
    // command[1:0]
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // interp_value[31:0]
    output logic [31:0]  m_tdata,
    // status[1:0]
    output logic [1:0]   m_tuser
);

    localparam int GW = (GRID_DEPTH > 1) ? $clog2(GRID_DEPTH) : 1;
    localparam int SW = (SAMPLE_DEPTH > 1) ? $clog2(SAMPLE_DEPTH) : 1;

    // input fields
    logic [15:0] in_address;
    logic [15:0] in_coord;
    logic [31:0] in_sample;
    logic [23:0] in_qx;
    logic [23:0] in_qy;
    assign in_address = s_tdata[15:0];
    assign in_coord   = s_tdata[31:16];
    assign in_sample  = s_tdata[63:32];
    assign in_qx      = s_tdata[87:64];
    assign in_qy      = s_tdata[111:88];

    // memories
    logic [15:0] x_mem [GRID_DEPTH];
    logic [15:0] y_mem [GRID_DEPTH];
    logic [31:0] s_mem [SAMPLE_DEPTH];
    logic [15:0] x_rdata_reg;
    logic [15:0] y_rdata_reg;
    logic [31:0] s_rdata_reg;
    logic [GW-1:0] x_ra;
    logic [GW-1:0] y_ra;
    logic [SW-1:0] s_ra;

    rbi_state_t state_reg, state_next;

    logic [7:0] last_x_reg;
    logic [7:0] last_y_reg;
    logic [8:0] row_step_reg;

    logic        accept;
    logic [23:0] qx_reg, qy_reg;
    logic [GW-1:0] lbx_reg, ubx_reg, lby_reg, uby_reg;
    logic [GW-1:0] lbx_nx, ubx_nx, lby_nx, uby_nx;
    logic [GW:0]   sumx, sumy;
    logic [GW-1:0] midx, midy;
    logic [GW-1:0] bndx, bndy;
    logic [GW-1:0] ixv, iyv, ixm1, iym1;
    logic          search_done;

    logic [15:0] x1_reg, x2_reg, y1_reg, y2_reg;
    logic signed [16:0] dx, dy;
    logic signed [33:0] den_reg;
    logic signed [25:0] wx1_reg, wx2_reg, wy1_reg, wy2_reg;
    logic [31:0] r0_reg, r1_reg;
    logic [31:0] s_full;
    logic [31:0] smp_reg [4];
    logic [2:0]  smp_cnt_reg;
    logic        zero_span_reg;

    logic [3:0]  mac_cnt_reg;
    logic signed [32:0] mul_a;
    logic signed [25:0] mul_b;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] a_reg, b_reg;
    logic signed [NUM_W-1:0]  num_reg;
    logic signed [NUM_W-1:0]  prod_ext;

    logic [NUM_W-1:0]  mag_reg;
    logic [NUM_W-1:0]  q_reg;
    logic [DM_W-1:0]   rem_reg, dmag_reg, rem_sh;
    logic [33:0]       den_abs;
    logic              neg_reg;
    logic [DIV_CW-1:0] div_cnt_reg;

    logic        m_valid_reg;
    logic [31:0] m_data_reg;
    logic [1:0]  m_user_reg;
    logic        out_load;
    logic [31:0] res_value;
    logic [1:0]  res_status;
    logic [31:0] sat_limit;
    logic        sat;

    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;
    assign m_tuser   = m_user_reg;

    // search bounds and step
    assign bndx = (32'(last_x_reg) > GRID_DEPTH - 1) ? GW'(GRID_DEPTH - 1) : GW'(last_x_reg);
    assign bndy = (32'(last_y_reg) > GRID_DEPTH - 1) ? GW'(GRID_DEPTH - 1) : GW'(last_y_reg);
    assign sumx = {1'b0, lbx_reg} + {1'b0, ubx_reg};
    assign sumy = {1'b0, lby_reg} + {1'b0, uby_reg};
    assign midx = sumx[GW:1];
    assign midy = sumy[GW:1];

    always_comb
    begin
        lbx_nx = lbx_reg;
        ubx_nx = ubx_reg;
        lby_nx = lby_reg;
        uby_nx = uby_reg;
        if (lbx_reg < ubx_reg)
        begin
            if ({x_rdata_reg, 8'd0} < qx_reg)
                lbx_nx = midx + GW'(1);
            else
                ubx_nx = midx;
        end
        if (lby_reg < uby_reg)
        begin
            if ({y_rdata_reg, 8'd0} < qy_reg)
                lby_nx = midy + GW'(1);
            else
                uby_nx = midy;
        end
    end

    assign search_done = (lbx_nx >= ubx_nx) && (lby_nx >= uby_nx);

    assign ixv  = (lbx_reg == '0) ? GW'(1) : lbx_reg;
    assign iyv  = (lby_reg == '0) ? GW'(1) : lby_reg;
    assign ixm1 = ixv - GW'(1);
    assign iym1 = iyv - GW'(1);

    assign dx = $signed({1'b0, x2_reg}) - $signed({1'b0, x1_reg});
    assign dy = $signed({1'b0, y2_reg}) - $signed({1'b0, y1_reg});

    always_comb
    begin
        case (smp_cnt_reg[1:0])
            2'd0:    s_full = r0_reg + 32'(ixm1);
            2'd1:    s_full = r0_reg + 32'(ixv);
            2'd2:    s_full = r1_reg + 32'(ixm1);
            default: s_full = r1_reg + 32'(ixv);
        endcase
    end

    // MAC operand schedule
    always_comb
    begin
        case (mac_cnt_reg)
            4'd0:
            begin
                mul_a = {smp_reg[0][31], smp_reg[0]};
                mul_b = wx2_reg;
            end
            4'd1:
            begin
                mul_a = {smp_reg[1][31], smp_reg[1]};
                mul_b = wx1_reg;
            end
            4'd2:
            begin
                mul_a = {smp_reg[2][31], smp_reg[2]};
                mul_b = wx2_reg;
            end
            4'd3:
            begin
                mul_a = {smp_reg[3][31], smp_reg[3]};
                mul_b = wx1_reg;
            end
            4'd5:
            begin
                mul_a = {1'b0, a_reg[31:0]};
                mul_b = wy2_reg;
            end
            4'd6:
            begin
                mul_a = 33'($signed(a_reg[PROD_W-1:32]));
                mul_b = wy2_reg;
            end
            4'd7:
            begin
                mul_a = {1'b0, b_reg[31:0]};
                mul_b = wy1_reg;
            end
            4'd8:
            begin
                mul_a = 33'($signed(b_reg[PROD_W-1:32]));
                mul_b = wy1_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_ext = {{(NUM_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign den_abs  = den_reg[33] ? 34'(-den_reg) : 34'(den_reg);
    assign rem_sh   = {rem_reg[DM_W-2:0], mag_reg[NUM_W-1]};

    // result formatting
    assign sat_limit = neg_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    assign sat       = (q_reg[NUM_W-1:32] != '0) || (q_reg[31:0] > sat_limit);
    always_comb
    begin
        if (zero_span_reg)
        begin
            res_value  = '0;
            res_status = ST_ZERO;
        end
        else if (sat)
        begin
            res_value  = sat_limit;
            res_status = ST_SAT;
        end
        else
        begin
            res_value  = neg_reg ? (32'd0 - q_reg[31:0]) : q_reg[31:0];
            res_status = ST_OK;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (accept && s_tuser == CMD_QUERY)
                    state_next = S_SEARCH_RD;
            S_SEARCH_RD:
                if ((lbx_reg >= ubx_reg) && (lby_reg >= uby_reg))
                    state_next = S_LO_RD;
                else
                    state_next = S_SEARCH_CMP;
            S_SEARCH_CMP:
                state_next = search_done ? S_LO_RD : S_SEARCH_RD;
            S_LO_RD:
                state_next = S_HI_RD;
            S_HI_RD:
                state_next = S_HI_CAP;
            S_HI_CAP:
                state_next = S_DEN;
            S_DEN:
                state_next = S_SMP;
            S_SMP:
                if (smp_cnt_reg == 3'd0 && den_reg == '0)
                    state_next = S_DONE;
                else if (smp_cnt_reg == 3'd4)
                    state_next = S_MAC;
            S_MAC:
                if (mac_cnt_reg == 4'd9)
                    state_next = S_DIV_INIT;
            S_DIV_INIT:
                state_next = S_DIV;
            S_DIV:
                if (div_cnt_reg == DIV_CW'(NUM_W - 1))
                    state_next = S_DONE;
            S_DONE:
                if (!m_valid_reg || m_tready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        s_tready = (state_reg == S_IDLE);
        out_load = (state_reg == S_DONE) && (!m_valid_reg || m_tready);
        x_ra     = midx;
        y_ra     = midy;
        s_ra     = s_full[SW-1:0];
        case (state_reg)
            S_LO_RD:
            begin
                x_ra = ixm1;
                y_ra = iym1;
            end
            S_HI_RD:
            begin
                x_ra = ixv;
                y_ra = iyv;
            end
            default:
            begin
                x_ra = midx;
                y_ra = midy;
            end
        endcase
    end

    // memories
    always_ff @(posedge clk)
    begin
        if (accept && s_tuser == CMD_WR_X && 32'(in_address) < GRID_DEPTH)
            x_mem[GW'(in_address)] <= in_coord;
        x_rdata_reg <= x_mem[x_ra];
    end

    always_ff @(posedge clk)
    begin
        if (accept && s_tuser == CMD_WR_Y && 32'(in_address) < GRID_DEPTH)
            y_mem[GW'(in_address)] <= in_coord;
        y_rdata_reg <= y_mem[y_ra];
    end

    always_ff @(posedge clk)
    begin
        if (accept && s_tuser == CMD_WR_SMP && 32'(in_address) < SAMPLE_DEPTH)
            s_mem[SW'(in_address)] <= in_sample;
        s_rdata_reg <= s_mem[s_ra];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            last_x_reg   <= 8'd1;
            last_y_reg   <= 8'd1;
            row_step_reg <= 9'd256;
            m_valid_reg  <= 1'b0;
            smp_cnt_reg  <= '0;
            mac_cnt_reg  <= '0;
            div_cnt_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_LAST_X:   last_x_reg   <= cfg_data[7:0];
                    CFG_LAST_Y:   last_y_reg   <= cfg_data[7:0];
                    CFG_ROW_STEP: row_step_reg <= cfg_data;
                    default:      ;
                endcase
            end
            if (out_load)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
            smp_cnt_reg <= (state_reg == S_SMP) ? smp_cnt_reg + 3'd1 : '0;
            mac_cnt_reg <= (state_reg == S_MAC) ? mac_cnt_reg + 4'd1 : '0;
            div_cnt_reg <= (state_reg == S_DIV) ? div_cnt_reg + DIV_CW'(1) : '0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                qx_reg        <= in_qx;
                qy_reg        <= in_qy;
                lbx_reg       <= '0;
                lby_reg       <= '0;
                ubx_reg       <= bndx;
                uby_reg       <= bndy;
                zero_span_reg <= 1'b0;
            end
            S_SEARCH_CMP:
            begin
                lbx_reg <= lbx_nx;
                ubx_reg <= ubx_nx;
                lby_reg <= lby_nx;
                uby_reg <= uby_nx;
            end
            S_HI_RD:
            begin
                x1_reg <= x_rdata_reg;
                y1_reg <= y_rdata_reg;
            end
            S_HI_CAP:
            begin
                x2_reg <= x_rdata_reg;
                y2_reg <= y_rdata_reg;
            end
            S_DEN:
            begin
                den_reg <= dx * dy;
                wx2_reg <= $signed({2'b00, x2_reg, 8'd0}) - $signed({2'b00, qx_reg});
                wx1_reg <= $signed({2'b00, qx_reg}) - $signed({2'b00, x1_reg, 8'd0});
                wy2_reg <= $signed({2'b00, y2_reg, 8'd0}) - $signed({2'b00, qy_reg});
                wy1_reg <= $signed({2'b00, qy_reg}) - $signed({2'b00, y1_reg, 8'd0});
                r0_reg  <= 32'(iym1) * 32'(row_step_reg);
                r1_reg  <= 32'(iyv) * 32'(row_step_reg);
            end
            S_SMP:
            begin
                if (smp_cnt_reg == 3'd0 && den_reg == '0)
                    zero_span_reg <= 1'b1;
                if (smp_cnt_reg != 3'd0)
                    smp_reg[smp_cnt_reg[1:0] - 2'd1] <= s_rdata_reg;
            end
            S_MAC:
            begin
                prod_reg <= mul_a * mul_b;
                case (mac_cnt_reg)
                    4'd1:    a_reg   <= prod_reg;
                    4'd2:    a_reg   <= a_reg + prod_reg;
                    4'd3:    b_reg   <= prod_reg;
                    4'd4:    b_reg   <= b_reg + prod_reg;
                    4'd6:    num_reg <= prod_ext;
                    4'd7:    num_reg <= num_reg + (prod_ext <<< 32);
                    4'd8:    num_reg <= num_reg + prod_ext;
                    4'd9:    num_reg <= num_reg + (prod_ext <<< 32);
                    default: ;
                endcase
            end
            S_DIV_INIT:
            begin
                neg_reg  <= num_reg[NUM_W-1] ^ den_reg[33];
                mag_reg  <= num_reg[NUM_W-1] ? NUM_W'(-num_reg) : NUM_W'(num_reg);
                dmag_reg <= {den_abs[DM_W-17:0], 16'd0};
                rem_reg  <= '0;
                q_reg    <= '0;
            end
            S_DIV:
            begin
                mag_reg <= {mag_reg[NUM_W-2:0], 1'b0};
                if (rem_sh >= dmag_reg)
                begin
                    rem_reg <= rem_sh - dmag_reg;
                    q_reg   <= {q_reg[NUM_W-2:0], 1'b1};
                end
                else
                begin
                    rem_reg <= rem_sh;
                    q_reg   <= {q_reg[NUM_W-2:0], 1'b0};
                end
            end
            default: ;
        endcase
        if (out_load)
        begin
            m_data_reg <= res_value;
            m_user_reg <= res_status;
        end
    end

endmodule

// File: tb/rectilinear_bilinear_interp_unit_tb.sv
// Self-checking testbench for the rectilinear bilinear interpolation unit.
`timescale 1ns / 1ps

module rectilinear_bilinear_interp_unit_tb;
    import rbi_pkg::*;

    localparam logic [1:0] CFG_SPARE = 2'd3;   // index past the register list
    localparam int CYCLE_LIMIT = 3000000;
    localparam int RAND_PER_PHASE = 40;

    typedef struct {
        logic [1:0]   cmd;
        logic [111:0] data;
        bit           has_res;
        logic [31:0]  val;
        logic [1:0]   st;
        bit           drain;
    } beat_t;

    typedef struct {
        logic [31:0] val;
        logic [1:0]  st;
    } interp_res_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = '0;
    logic [8:0]   cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [111:0] s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [31:0]  m_tdata;
    logic [1:0]   m_tuser;

    // shadow of the block's tables and registers, advanced as beats are queued
    logic [15:0]        xg [256];
    logic [15:0]        yg [256];
    logic signed [31:0] smp [65536];
    bit                 smp_ok [65536];
    int unsigned        bnd_x = 1;
    int unsigned        bnd_y = 1;
    int unsigned        rs = 256;

    beat_t       pend_beats[$];
    interp_res_t interp_exp[$];
    beat_t       cur;
    int          errors = 0;
    int          n_query = 0, n_sat = 0, n_zero = 0, n_results = 0;
    int          gap_left = 0, stall_left = 0;
    int          gap_max = 0, stall_max = 0;
    bit          rx_block = 1'b0;
    longint      cycles = 0;
    bit          busy;

    rectilinear_bilinear_interp_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("** rectilinear_bilinear_interp_unit: FAILED **");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        errors++;
    endtask

    function automatic int unsigned find_cell(input bit on_y, input logic [23:0] qv);
        int unsigned lo, hi, mid;
        logic [15:0] g;
        lo = 0;
        hi = on_y ? bnd_y : bnd_x;
        while (lo < hi)
        begin
            mid = (lo + hi) / 2;
            g = on_y ? yg[mid] : xg[mid];
            if ({g, 8'h00} < qv)
                lo = mid + 1;
            else
                hi = mid;
        end
        return (lo == 0) ? 1 : lo;
    endfunction

    function automatic logic [15:0] corner_addr(input int unsigned row, input int unsigned col);
        logic [31:0] a;
        a = row * rs + col;
        return a[15:0];
    endfunction

    function automatic longint sample_of(input logic [15:0] a);
        longint v;
        v = smp[a];
        return v;
    endfunction

    function automatic void interp_point(input logic [23:0] qx, input logic [23:0] qy,
                                         output logic [31:0] val, output logic [1:0] st);
        int unsigned ix, iy;
        longint x1, x2, y1, y2, den, wx1, wx2, wy1, wy2, ra, rb;
        logic signed [127:0] ea, eb, ew1, ew2, num, dd, quo;
        ix = find_cell(1'b0, qx);
        iy = find_cell(1'b1, qy);
        x1 = xg[ix-1];
        x2 = xg[ix];
        y1 = yg[iy-1];
        y2 = yg[iy];
        den = (x2 - x1) * (y2 - y1);
        if (den == 0)
        begin
            val = '0;
            st = ST_ZERO;
            return;
        end
        wx2 = x2 * 256 - longint'(qx);
        wx1 = longint'(qx) - x1 * 256;
        wy2 = y2 * 256 - longint'(qy);
        wy1 = longint'(qy) - y1 * 256;
        ra = sample_of(corner_addr(iy - 1, ix - 1)) * wx2 + sample_of(corner_addr(iy - 1, ix)) * wx1;
        rb = sample_of(corner_addr(iy, ix - 1)) * wx2 + sample_of(corner_addr(iy, ix)) * wx1;
        ea = ra;
        eb = rb;
        ew1 = wy1;
        ew2 = wy2;
        num = ea * ew2 + eb * ew1;
        dd = den;
        dd = dd * 65536;
        quo = num / dd;   // truncates toward zero
        if (quo > 128'sd2147483647)
        begin
            val = 32'h7FFFFFFF;
            st = ST_SAT;
        end
        else if (quo < -128'sd2147483648)
        begin
            val = 32'h80000000;
            st = ST_SAT;
        end
        else
        begin
            val = quo[31:0];
            st = ST_OK;
        end
    endfunction

    task automatic push_beat(input logic [1:0] cmd, input logic [15:0] addr,
                             input logic [15:0] coord, input logic [31:0] sv,
                             input logic [23:0] qx, input logic [23:0] qy, input bit drain);
        beat_t b;
        b.cmd = cmd;
        b.data = {qy, qx, sv, coord, addr};
        b.has_res = 1'b0;
        b.val = '0;
        b.st = ST_OK;
        b.drain = drain;
        case (cmd)
            CMD_WR_X:   if (addr < 256) xg[addr] = coord;
            CMD_WR_Y:   if (addr < 256) yg[addr] = coord;
            CMD_WR_SMP:
            begin
                smp[addr] = sv;
                smp_ok[addr] = 1'b1;
            end
            default:
            begin
                b.has_res = 1'b1;
                interp_point(qx, qy, b.val, b.st);
                n_query++;
                if (b.st == ST_SAT) n_sat++;
                if (b.st == ST_ZERO) n_zero++;
            end
        endcase
        pend_beats.push_back(b);
    endtask

    function automatic logic [31:0] rand_sample();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return $urandom_range(0, 32'h003FFFFF) - 32'h00200000;
        else if (r == 6)
            return 32'h7FFFFFFF;
        else if (r == 7)
            return 32'h80000000;
        return $urandom;
    endfunction

    // a query only reads samples that were written before
    task automatic send_query(input logic [23:0] qx, input logic [23:0] qy, input bit drain);
        int unsigned ix, iy;
        logic [15:0] ca [4];
        bit first;
        first = drain;
        ix = find_cell(1'b0, qx);
        iy = find_cell(1'b1, qy);
        ca[0] = corner_addr(iy - 1, ix - 1);
        ca[1] = corner_addr(iy - 1, ix);
        ca[2] = corner_addr(iy, ix - 1);
        ca[3] = corner_addr(iy, ix);
        foreach (ca[k])
            if (!smp_ok[ca[k]])
            begin
                push_beat(CMD_WR_SMP, ca[k], $urandom, rand_sample(), $urandom, $urandom, first);
                first = 1'b0;
            end
        push_beat(CMD_QUERY, $urandom, $urandom, $urandom, qx, qy, first);
    endtask

    function automatic logic [23:0] near_point(input bit on_y);
        int k, v;
        k = $urandom_range(0, 255);
        v = (on_y ? yg[k] : xg[k]) * 256 + int'($urandom_range(0, 2047)) - 1024;
        if (v < 0) v = 0;
        if (v > 24'hFFFFFF) v = 24'hFFFFFF;
        return v[23:0];
    endfunction

    // rewrites entries 0..count-1 of both grid tables
    task automatic fill_tables(input bit descending, input int count);
        int v, prev_x, prev_y;
        prev_x = 0;
        prev_y = 0;
        for (int i = 0; i < count; i++)
        begin
            v = descending ? 64000 - i * 250 - int'($urandom_range(0, 200))
                           : i * 250 + int'($urandom_range(0, 200));
            // occasional repeated coordinate gives a zero-width cell
            push_beat(CMD_WR_X, i, ($urandom_range(0, 11) == 0 && i > 0) ? prev_x : v,
                      $urandom, $urandom, $urandom, 1'b0);
            prev_x = xg[i];
            v = descending ? 63000 - i * 240 : i * 245 + int'($urandom_range(0, 150));
            push_beat(CMD_WR_Y, i, ($urandom_range(0, 11) == 0 && i > 0) ? prev_y : v,
                      $urandom, $urandom, $urandom, 1'b0);
            prev_y = yg[i];
        end
    endtask

    task automatic wait_idle();
        while (pend_beats.size() != 0 || s_tvalid || interp_exp.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [8:0] v);
        @(posedge clk);
        cfg_index <= idx;
        cfg_data <= v;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_LAST_X:   bnd_x = v[7:0];
            CFG_LAST_Y:   bnd_y = v[7:0];
            CFG_ROW_STEP: rs = v;
            default: ;
        endcase
    endtask

    task automatic random_items(input int count);
        int unsigned r;
        logic [15:0] a;
        for (int n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 55)
                send_query(near_point(1'b0), near_point(1'b1), n == count / 2);
            else if (r < 62)
                send_query($urandom, $urandom, 1'b0);
            else if (r < 78)
                push_beat(CMD_WR_SMP, $urandom, $urandom, rand_sample(), $urandom, $urandom, 1'b0);
            else if (r < 89)
            begin
                a = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 255));
                push_beat(CMD_WR_X, a, (a < 256) ? xg[a[7:0]] + 16'($urandom_range(0, 40)) - 16'd20
                                                 : 16'($urandom),
                          $urandom, $urandom, $urandom, 1'b0);
            end
            else
            begin
                a = ($urandom_range(0, 4) == 0) ? 16'($urandom) : 16'($urandom_range(0, 255));
                push_beat(CMD_WR_Y, a, (a < 256) ? yg[a[7:0]] + 16'($urandom_range(0, 40)) - 16'd20
                                                 : 16'($urandom),
                          $urandom, $urandom, $urandom, 1'b0);
            end
        end
    endtask

    // input side: one beat at a time from the pending queue
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            busy = s_tvalid && !s_tready;
            if (s_tvalid && s_tready && cur.has_res)
                interp_exp.push_back('{val: cur.val, st: cur.st});
            if (!busy)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (pend_beats.size() != 0 &&
                         !(pend_beats[0].drain && interp_exp.size() != 0))
                begin
                    cur = pend_beats.pop_front();
                    s_tdata <= cur.data;
                    s_tuser <= cur.cmd;
                    s_tvalid <= 1'b1;
                    gap_left = $urandom_range(0, gap_max);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // output side: check each result beat against the oldest expectation
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                n_results++;
                if (interp_exp.size() == 0)
                    report_mismatch($sformatf("unexpected result %h status %0d", m_tdata, m_tuser));
                else
                begin
                    interp_res_t e;
                    e = interp_exp.pop_front();
                    if (m_tdata !== e.val)
                        report_mismatch($sformatf("interp_value %h, want %h", m_tdata, e.val));
                    if (m_tuser !== e.st)
                        report_mismatch($sformatf("status %0d, want %0d", m_tuser, e.st));
                end
                stall_left = $urandom_range(0, stall_max);
            end
            if (rx_block)
                m_tready <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    initial
    begin
        logic [8:0] cfg_set [7][3];
        cfg_set = '{'{9'd255, 9'd255, 9'd256}, '{9'd0, 9'd0, 9'd1},
                    '{9'd7, 9'd3, 9'd511}, '{9'h1FF, 9'd255, 9'd0},
                    '{9'd128, 9'd200, 9'd300}, '{9'h100, 9'd17, 9'd256},
                    '{9'd1, 9'd1, 9'd256}};
        foreach (smp_ok[i]) smp_ok[i] = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset register values, grid corners and field extremes
        fill_tables(1'b0, 256);
        push_beat(CMD_WR_X, 16'hFFFF, 16'hFFFF, '0, '0, '0, 1'b0);
        push_beat(CMD_WR_SMP, 16'd0, '0, 32'h7FFFFFFF, '0, '0, 1'b0);
        push_beat(CMD_WR_SMP, 16'd1, '0, 32'h80000000, '0, '0, 1'b0);
        push_beat(CMD_WR_SMP, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b0);
        send_query(24'h0, 24'h0, 1'b0);
        send_query(24'hFFFFFF, 24'hFFFFFF, 1'b0);
        send_query({xg[1], 8'h00}, {yg[1], 8'h00}, 1'b0);
        send_query({xg[0], 8'h80}, {yg[0], 8'h40}, 1'b0);
        send_query(24'hFFFFFF, 24'h0, 1'b0);
        send_query(24'h0, 24'hFFFFFF, 1'b1);
        wait_idle();
        write_reg(CFG_SPARE, 9'h1FF);
        send_query({xg[0], 8'h10}, {yg[0], 8'h10}, 1'b0);
        wait_idle();

        foreach (cfg_set[p])
        begin
            if (p == 3)
            begin
                // descending run at the low end of the tables
                fill_tables(1'b1, 48);
                wait_idle();
            end
            write_reg(CFG_LAST_X, cfg_set[p][0]);
            write_reg(CFG_LAST_Y, cfg_set[p][1]);
            write_reg(CFG_ROW_STEP, cfg_set[p][2]);
            gap_max = (p % 3 == 1) ? 0 : 6;
            stall_max = (p % 3 == 2) ? 0 : 6;
            random_items(RAND_PER_PHASE);
            if (p == 2)
            begin
                // hold the output long enough for the input to back up
                rx_block = 1'b1;
                repeat (3000) @(posedge clk);
                rx_block = 1'b0;
            end
            wait_idle();
        end

        if (interp_exp.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", interp_exp.size()));
        $display("queries %0d (saturated %0d, zero span %0d), results seen %0d",
                 n_query, n_sat, n_zero, n_results);
        $display("register settings %0d, ascending and descending grids, %0d mismatches",
                 $size(cfg_set) + 1, errors);
        if (errors == 0)
            $display("** rectilinear_bilinear_interp_unit: PASSED **");
        else
            $display("** rectilinear_bilinear_interp_unit: FAILED **");
        $finish;
    end

endmodule
